FILE: rtl/spa_pkg.sv
// package for the sparse polynomial adder
// shared term type, chain control struct and constants; no dependencies
`default_nettype none

package spa_pkg;

   localparam int unsigned MAX_TERMS_DEF = 16;
   localparam int unsigned COEF_W        = 32;
   localparam int unsigned EXP_W         = 16;

   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   localparam logic REQ_FIRST  = 1'b0;
   localparam logic REQ_SECOND = 1'b1;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic signed [EXP_W-1:0]  exp;
   } term_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } chain_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/sparse_polynomial_adder_core.sv
// top level of the sparse polynomial adder
// depends on spa_pkg, spa_chain and spa_cell
`default_nettype none

// usage
//  - request channel: a term request is taken at a clock edge with start high and
//    busy low. req_type picks the operand, req_no_term marks a request with no
//    term, req_last_term on the second operand ends loading and starts the sum
//  - loading: one term request per cycle; each operand sits in a chain of
//    MAX_TERMS cells that inserts the term in sorted place in that same cycle.
//    a term that finds its chain full is dropped and sets the overflow flag
//  - summing: after the ending request busy stays high while the two chain
//    heads are compared and popped, one step per cycle; a result is held
//    until the next formed result or the end of the sum shows whether it is
//    last (both heads of a pair with equal exponents are popped together)
//  - results: each sum term shows on the rsp_ ports for one cycle with
//    rsp_valid high; rsp_last marks the final one, and a fully cancelled sum
//    gives one result with rsp_empty_res set. the receiver cannot stall
//  - reset: synchronous; both chains come up empty, overflow clear, idle
//  - after the final result both chains are empty and the flag is clear

module sparse_polynomial_adder_core #(
   parameter int unsigned MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_type,
   input  wire logic signed [spa_pkg::COEF_W-1:0]   req_coef_in,
   input  wire logic signed [spa_pkg::EXP_W-1:0]    req_exp_in,
   input  wire logic                                req_no_term,
   input  wire logic                                req_last_term,
   output logic                                     rsp_valid,
   output logic signed [spa_pkg::COEF_W-1:0]        rsp_sum_coef,
   output logic signed [spa_pkg::EXP_W-1:0]         rsp_sum_exp,
   output logic                                     rsp_last,
   output logic                                     rsp_empty_res,
   output logic                                     rsp_overflow
);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type state_ff;

   logic accept;
   spa_pkg::term_type      new_term;
   spa_pkg::chain_ctrl_type ctrl_a, ctrl_b;
   spa_pkg::term_type      head_a, head_b;
   logic                   valid_a, valid_b, full_a, full_b;

   // drop flag and the held result that waits to learn whether it is last
   logic                   dropped_ff;
   logic                   hold_valid_ff;
   spa_pkg::term_type      hold_ff;

   // output registers
   logic                          rsp_valid_ff, rsp_last_ff, rsp_empty_ff, rsp_ovf_ff;
   logic signed [spa_pkg::COEF_W-1:0] rsp_coef_ff;
   logic signed [spa_pkg::EXP_W-1:0]  rsp_exp_ff;

   // merge step signals
   logic                           merging, exp_eq, exp_lt;
   logic signed [spa_pkg::COEF_W:0] wide_sum;
   logic [spa_pkg::COEF_W-1:0]     sat_sum;
   logic                           pop_a, pop_b, prod_valid, done;
   spa_pkg::term_type              prod;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign new_term.coef = req_coef_in;
   assign new_term.exp  = req_exp_in;

   // ------------------------------------------------------------------
   // operand chains: insertion while loading, popping while summing
   // ------------------------------------------------------------------
   assign merging = (state_ff == ST_MERGE);

   assign ctrl_a.insert = accept && !req_no_term && (req_type == spa_pkg::REQ_FIRST) && !full_a;
   assign ctrl_a.pop    = merging && pop_a;
   assign ctrl_b.insert = accept && !req_no_term && (req_type == spa_pkg::REQ_SECOND) && !full_b;
   assign ctrl_b.pop    = merging && pop_b;

   spa_chain #(.DEPTH(MAX_TERMS)) u_chain_a (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_a),
      .new_term   (new_term),
      .head_term  (head_a),
      .head_valid (valid_a),
      .full       (full_a)
   );

   spa_chain #(.DEPTH(MAX_TERMS)) u_chain_b (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_b),
      .new_term   (new_term),
      .head_term  (head_b),
      .head_valid (valid_b),
      .full       (full_b)
   );

   // ------------------------------------------------------------------
   // merge step: compare heads, saturating add on equal exponents
   // ------------------------------------------------------------------
   assign exp_eq   = (head_a.exp == head_b.exp);
   assign exp_lt   = ($signed(head_a.exp) < $signed(head_b.exp));
   assign wide_sum = {head_a.coef[spa_pkg::COEF_W-1], head_a.coef}
                   + {head_b.coef[spa_pkg::COEF_W-1], head_b.coef};

   always_comb begin
      if (wide_sum[spa_pkg::COEF_W] != wide_sum[spa_pkg::COEF_W-1]) begin
         sat_sum = wide_sum[spa_pkg::COEF_W] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
      end else begin
         sat_sum = wide_sum[spa_pkg::COEF_W-1:0];
      end
   end

   always_comb begin
      pop_a      = 1'b0;
      pop_b      = 1'b0;
      prod_valid = 1'b0;
      prod       = head_a;
      done       = 1'b0;
      if (valid_a && valid_b) begin
         if (exp_eq) begin
            pop_a      = 1'b1;
            pop_b      = 1'b1;
            prod.coef  = sat_sum;
            prod_valid = (sat_sum != '0);   // cancelled pair gives nothing
         end else if (exp_lt) begin
            pop_a      = 1'b1;
            prod_valid = 1'b1;
         end else begin
            pop_b      = 1'b1;
            prod       = head_b;
            prod_valid = 1'b1;
         end
      end else if (valid_a) begin
         pop_a      = 1'b1;
         prod_valid = 1'b1;
      end else if (valid_b) begin
         pop_b      = 1'b1;
         prod       = head_b;
         prod_valid = 1'b1;
      end else begin
         done = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // sequencer, hold stage and output registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dropped_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  if (!req_no_term && (req_type == spa_pkg::REQ_FIRST ? full_a : full_b)) begin
                     dropped_ff <= 1'b1;
                  end
                  if ((req_type == spa_pkg::REQ_SECOND) && req_last_term) begin
                     state_ff <= ST_MERGE;
                  end
               end
            end
            ST_MERGE: begin
               if (done) begin
                  // flush the held term as the last one, or report an empty sum
                  rsp_valid_ff  <= 1'b1;
                  rsp_last_ff   <= 1'b1;
                  rsp_empty_ff  <= !hold_valid_ff;
                  rsp_coef_ff   <= hold_valid_ff ? hold_ff.coef : '0;
                  rsp_exp_ff    <= hold_valid_ff ? hold_ff.exp : '0;
                  rsp_ovf_ff    <= dropped_ff;
                  hold_valid_ff <= 1'b0;
                  dropped_ff    <= 1'b0;
                  state_ff      <= ST_IDLE;
               end else if (prod_valid) begin
                  // a newer term exists, so the held one is not last
                  rsp_valid_ff <= hold_valid_ff;
                  if (hold_valid_ff) begin
                     rsp_last_ff  <= 1'b0;
                     rsp_empty_ff <= 1'b0;
                     rsp_coef_ff  <= hold_ff.coef;
                     rsp_exp_ff   <= hold_ff.exp;
                     rsp_ovf_ff   <= dropped_ff;
                  end
                  hold_ff       <= prod;
                  hold_valid_ff <= 1'b1;
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_coef  = rsp_coef_ff;
   assign rsp_sum_exp   = rsp_exp_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_overflow  = rsp_ovf_ff;

`ifndef SYNTHESIS
   // results only come out of a running sum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a running sum");

   // an empty sum is a single last result with zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_last && rsp_sum_coef == '0 && rsp_sum_exp == '0))
      else $error("empty result malformed");

   // the sum ends exactly with its last result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_last))
      else $error("sum ended without a last result");

   // chains are drained when the block goes idle
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (!valid_a && !valid_b))
      else $error("operand left behind after sum");
`endif

endmodule

`default_nettype wire

FILE: rtl/spa_cell.sv
// one storage cell of a sorted term chain
// depends on spa_pkg
`default_nettype none

module spa_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire spa_pkg::chain_ctrl_type ctrl,
   input  wire spa_pkg::term_type       new_term,
   input  wire spa_pkg::term_type       left_term,
   input  wire logic                    left_valid,
   input  wire logic                    left_ge,
   input  wire spa_pkg::term_type       right_term,
   input  wire logic                    right_valid,
   output spa_pkg::term_type            term,
   output logic                         valid,
   output logic                         ge
);

   spa_pkg::term_type term_ff, term_in;
   logic              valid_ff, valid_in;

   // stored exponent at or above the new one: new term goes ahead of it
   assign ge = valid_ff && ($signed(term_ff.exp) >= $signed(new_term.exp));

   always_comb begin
      term_in  = term_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         if (left_ge) begin
            term_in  = left_term;
            valid_in = 1'b1;
         end else if (left_valid && (!valid_ff || ge)) begin
            term_in  = new_term;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop) begin
         term_in  = right_term;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      term_ff <= term_in;
   end

   assign term  = term_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

FILE: rtl/spa_chain.sv
// row of cells holding one polynomial sorted by ascending exponent
// depends on spa_pkg and spa_cell
`default_nettype none

module spa_chain #(
   parameter int unsigned DEPTH = spa_pkg::MAX_TERMS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire spa_pkg::chain_ctrl_type ctrl,
   input  wire spa_pkg::term_type       new_term,
   output spa_pkg::term_type            head_term,
   output logic                         head_valid,
   output logic                         full
);

   spa_pkg::term_type cell_term  [DEPTH+1];
   logic              cell_valid [DEPTH+1];
   logic              cell_ge    [DEPTH+1];

   // boundary past the tail
   assign cell_term[DEPTH]  = '0;
   assign cell_valid[DEPTH] = 1'b0;
   assign cell_ge[DEPTH]    = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spa_pkg::term_type l_term;
      logic              l_valid, l_ge;
      if (i == 0) begin : g_head
         assign l_term  = new_term;
         assign l_valid = 1'b1;
         assign l_ge    = 1'b0;
      end else begin : g_body
         assign l_term  = cell_term[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_ge    = cell_ge[i-1];
      end
      spa_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_term    (new_term),
         .left_term   (l_term),
         .left_valid  (l_valid),
         .left_ge     (l_ge),
         .right_term  (cell_term[i+1]),
         .right_valid (cell_valid[i+1]),
         .term        (cell_term[i]),
         .valid       (cell_valid[i]),
         .ge          (cell_ge[i])
      );
   end

   assign head_term  = cell_term[0];
   assign head_valid = cell_valid[0];
   assign full       = cell_valid[DEPTH-1];

endmodule

`default_nettype wire

FILE: verif/tb_sparse_polynomial_adder_core.sv
`timescale 1ns / 1ps

// self-checking testbench for sparse_polynomial_adder_core: directed and random term
// requests, a predictor of the sorted and merged sum, and a per-field response check
// depends on spa_pkg and the core rtl only

module tb_sparse_polynomial_adder_core;

   localparam int unsigned TERM_CAP    = spa_pkg::MAX_TERMS_DEF;
   localparam int unsigned ITEM_TARGET = 130;
   // the cycle limit is far above any correct run
   localparam int unsigned DRAIN_WAIT  = 2 * TERM_CAP + 8;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned MAX_REPORTS = 100;
   // room kept for one large random sum, noise included
   localparam int unsigned BIG_SUM_ROOM = 45;

   // one predicted response
   typedef struct packed {
      logic signed [spa_pkg::COEF_W-1:0] coef;
      logic signed [spa_pkg::EXP_W-1:0]  exp;
      logic                              last;
      logic                              empty;
      logic                              dropped;
   } sum_term_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_type;
   logic signed [spa_pkg::COEF_W-1:0] req_coef_in;
   logic signed [spa_pkg::EXP_W-1:0]  req_exp_in;
   logic                              req_no_term;
   logic                              req_last_term;
   logic                              rsp_valid;
   logic signed [spa_pkg::COEF_W-1:0] rsp_sum_coef;
   logic signed [spa_pkg::EXP_W-1:0]  rsp_sum_exp;
   logic                              rsp_last;
   logic                              rsp_empty_res;
   logic                              rsp_overflow;

   // predictor state: one sorted store per operand plus the drop flag
   spa_pkg::term_type op_terms [2][TERM_CAP];
   int unsigned       op_count [2];
   logic              drop_seen;
   sum_term_type      pending_sums [$];

   int unsigned  error_count    = 0;
   int unsigned  cycle_count    = 0;
   int unsigned  request_count  = 0;
   int unsigned  random_items   = 0;
   int unsigned  terms_checked  = 0;
   int unsigned  sums_done      = 0;
   int unsigned  dropped_sums   = 0;
   logic         idle_enable;

   sparse_polynomial_adder_core #(
      .MAX_TERMS(TERM_CAP)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_coef_in  (req_coef_in),
      .req_exp_in   (req_exp_in),
      .req_no_term  (req_no_term),
      .req_last_term(req_last_term),
      .rsp_valid    (rsp_valid),
      .rsp_sum_coef (rsp_sum_coef),
      .rsp_sum_exp  (rsp_sum_exp),
      .rsp_last     (rsp_last),
      .rsp_empty_res(rsp_empty_res),
      .rsp_overflow (rsp_overflow)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d sum terms still pending", cycle_count,
                  pending_sums.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic sum_term_type make_sum(input logic signed [spa_pkg::COEF_W-1:0] coef,
                                             input logic signed [spa_pkg::EXP_W-1:0]  expo);
      sum_term_type s;
      s.coef    = coef;
      s.exp     = expo;
      s.last    = 1'b0;
      s.empty   = 1'b0;
      s.dropped = drop_seen;
      return s;
   endfunction

   // update the operand stores for one accepted request and, on the ending request,
   // queue the whole merged sum
   task automatic load_and_sum(input logic op, input logic signed [spa_pkg::COEF_W-1:0] coef,
                               input logic signed [spa_pkg::EXP_W-1:0] expo,
                               input logic no_term, input logic last_term);
      int unsigned  pos;
      int unsigned  i;
      int unsigned  j;
      int unsigned  n_out;
      logic [spa_pkg::COEF_W:0]          wide;
      logic signed [spa_pkg::COEF_W-1:0] sum;
      sum_term_type out_terms [2*TERM_CAP];
      if (!no_term) begin
         if (op_count[op] >= TERM_CAP) begin
            // store full: the term is lost, the flag rides on the next sum
            drop_seen = 1'b1;
         end else begin
            // a new term goes ahead of stored terms with an equal exponent
            pos = 0;
            while (pos < op_count[op] && $signed(op_terms[op][pos].exp) < $signed(expo))
               pos++;
            for (i = op_count[op]; i > pos; i--)
               op_terms[op][i] = op_terms[op][i-1];
            op_terms[op][pos].coef = coef;
            op_terms[op][pos].exp  = expo;
            op_count[op]++;
         end
      end
      // an end mark only counts on the second operand
      if (op != spa_pkg::REQ_SECOND || !last_term)
         return;
      i = 0;
      j = 0;
      n_out = 0;
      // merge heads only: repeats inside one store are never folded together
      while (i < op_count[spa_pkg::REQ_FIRST] && j < op_count[spa_pkg::REQ_SECOND]) begin
         if ($signed(op_terms[spa_pkg::REQ_FIRST][i].exp)
             == $signed(op_terms[spa_pkg::REQ_SECOND][j].exp)) begin
            wide = {op_terms[spa_pkg::REQ_FIRST][i].coef[spa_pkg::COEF_W-1],
                    op_terms[spa_pkg::REQ_FIRST][i].coef}
                 + {op_terms[spa_pkg::REQ_SECOND][j].coef[spa_pkg::COEF_W-1],
                    op_terms[spa_pkg::REQ_SECOND][j].coef};
            if (wide[spa_pkg::COEF_W] != wide[spa_pkg::COEF_W-1])
               sum = wide[spa_pkg::COEF_W] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
            else
               sum = wide[spa_pkg::COEF_W-1:0];
            // a zero sum drops both terms
            if (sum != 0) begin
               out_terms[n_out] = make_sum(sum, op_terms[spa_pkg::REQ_FIRST][i].exp);
               n_out++;
            end
            i++;
            j++;
         end else if ($signed(op_terms[spa_pkg::REQ_FIRST][i].exp)
                      < $signed(op_terms[spa_pkg::REQ_SECOND][j].exp)) begin
            out_terms[n_out] = make_sum(op_terms[spa_pkg::REQ_FIRST][i].coef,
                                        op_terms[spa_pkg::REQ_FIRST][i].exp);
            n_out++;
            i++;
         end else begin
            out_terms[n_out] = make_sum(op_terms[spa_pkg::REQ_SECOND][j].coef,
                                        op_terms[spa_pkg::REQ_SECOND][j].exp);
            n_out++;
            j++;
         end
      end
      while (i < op_count[spa_pkg::REQ_FIRST]) begin
         out_terms[n_out] = make_sum(op_terms[spa_pkg::REQ_FIRST][i].coef,
                                     op_terms[spa_pkg::REQ_FIRST][i].exp);
         n_out++;
         i++;
      end
      while (j < op_count[spa_pkg::REQ_SECOND]) begin
         out_terms[n_out] = make_sum(op_terms[spa_pkg::REQ_SECOND][j].coef,
                                     op_terms[spa_pkg::REQ_SECOND][j].exp);
         n_out++;
         j++;
      end
      // everything cancelled: one empty response
      if (n_out == 0) begin
         out_terms[0] = make_sum('0, '0);
         out_terms[0].empty = 1'b1;
         n_out = 1;
      end
      out_terms[n_out-1].last = 1'b1;
      for (i = 0; i < n_out; i++)
         pending_sums.push_back(out_terms[i]);
      sums_done++;
      if (drop_seen)
         dropped_sums++;
      op_count[spa_pkg::REQ_FIRST]  = 0;
      op_count[spa_pkg::REQ_SECOND] = 0;
      drop_seen = 1'b0;
   endtask

   // drive one request at the falling edge, hold it until a rising edge sees busy low
   task automatic send_request(input logic op, input logic signed [spa_pkg::COEF_W-1:0] coef,
                               input logic signed [spa_pkg::EXP_W-1:0] expo,
                               input logic no_term, input logic last_term);
      while (idle_enable && $urandom_range(99) < 25) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start         <= 1'b1;
      req_type      <= op;
      req_coef_in   <= coef;
      req_exp_in    <= expo;
      req_no_term   <= no_term;
      req_last_term <= last_term;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      load_and_sum(op, coef, expo, no_term, last_term);
      request_count++;
   endtask

   // hold off new requests until every predicted term has come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_sums.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic signed [spa_pkg::EXP_W-1:0] pick_exponent();
      int unsigned roll;
      int          near_zero;
      logic [31:0] r;
      roll = $urandom_range(99);
      r = $urandom;
      near_zero = $urandom_range(8);
      near_zero = near_zero - 4;
      // a narrow pool makes equal exponents, hence sums and cancellations, common
      if (roll < 50)
         return near_zero[spa_pkg::EXP_W-1:0];
      if (roll < 58)
         return {1'b1, {(spa_pkg::EXP_W-1){1'b0}}};
      if (roll < 66)
         return {1'b0, {(spa_pkg::EXP_W-1){1'b1}}};
      return r[spa_pkg::EXP_W-1:0];
   endfunction

   function automatic logic signed [spa_pkg::COEF_W-1:0] pick_coefficient();
      int unsigned roll;
      logic [31:0] r;
      roll = $urandom_range(99);
      r = $urandom;
      if (roll < 10)
         return spa_pkg::COEF_MAX;
      if (roll < 20)
         return spa_pkg::COEF_MIN;
      if (roll < 25)
         return '0;
      if (roll < 55)
         return {{14{r[17]}}, r[17:0]};
      return r;
   endfunction

   // requests that load nothing and end nothing
   task automatic send_noise();
      logic pick;
      logic mark;
      pick = 1'($urandom_range(1));
      mark = 1'($urandom_range(1));
      if (pick)
         send_request(spa_pkg::REQ_FIRST, pick_coefficient(), pick_exponent(), 1'b1, mark);
      else
         send_request(spa_pkg::REQ_SECOND, pick_coefficient(), pick_exponent(), 1'b1, 1'b0);
   endtask

   function automatic void check_field(input string what, input logic signed [31:0] want_v,
                                       input logic signed [31:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s expected %0d actual %0d", $time, what, want_v, got_v);
      end
   endfunction

   // response check: every strobe is matched against the oldest predicted term
   always @(posedge clock) begin : response_check
      sum_term_type want;
      if (!reset && rsp_valid) begin
         if (pending_sums.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t ns: response with nothing expected, coef %0d exp %0d",
                        $time, rsp_sum_coef, rsp_sum_exp);
         end else begin
            want = pending_sums.pop_front();
            terms_checked++;
            check_field("sum_coef", want.coef, rsp_sum_coef);
            check_field("sum_exp", 32'(want.exp), 32'(rsp_sum_exp));
            check_field("last", 32'(want.last), 32'(rsp_last));
            check_field("empty_res", 32'(want.empty), 32'(rsp_empty_res));
            check_field("overflow", 32'(want.dropped), 32'(rsp_overflow));
         end
      end
   end

   // extreme exponents and coefficients; equal heads saturate high and low,
   // and the ending request carries a term that cancels
   task automatic test_extreme_terms();
      send_request(spa_pkg::REQ_FIRST, spa_pkg::COEF_MAX, 16'sh8000, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_FIRST, spa_pkg::COEF_MIN, 16'sh7fff, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_FIRST, 32'sd1, 16'sd0, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_SECOND, spa_pkg::COEF_MAX, 16'sh8000, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_SECOND, spa_pkg::COEF_MIN, 16'sh7fff, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_SECOND, -32'sd1, 16'sd0, 1'b0, 1'b1);
   endtask

   // a fully cancelled sum, then a sum of two empty operands
   task automatic test_cancelled_and_empty();
      send_request(spa_pkg::REQ_FIRST, 32'sh0001_0000, 16'sd3, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_SECOND, -32'sh0001_0000, 16'sd3, 1'b0, 1'b1);
      send_request(spa_pkg::REQ_SECOND, 32'shffff_ffff, 16'shffff, 1'b1, 1'b1);
   endtask

   // end marks on the first operand load their term but start nothing
   task automatic test_first_end_mark_ignored();
      send_request(spa_pkg::REQ_FIRST, 32'sh0001_8000, 16'sd2, 1'b0, 1'b1);
      send_request(spa_pkg::REQ_FIRST, 32'sh7777_7777, 16'sd5, 1'b1, 1'b1);
      send_request(spa_pkg::REQ_SECOND, '0, '0, 1'b1, 1'b1);
   endtask

   // repeated exponents in each store are paired head to head, not folded;
   // a zero coefficient that meets no partner still comes out
   task automatic test_repeated_exponents();
      send_request(spa_pkg::REQ_FIRST, 32'sd1, 16'sd4, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_FIRST, 32'sd2, 16'sd4, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_SECOND, 32'sd3, 16'sd4, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_SECOND, 32'sd4, 16'sd4, 1'b0, 1'b0);
      send_request(spa_pkg::REQ_SECOND, '0, 16'sd9, 1'b0, 1'b1);
   endtask

   // one well-formed sum with random content: terms of both operands in random
   // order, some matched to earlier exponents to force sums and cancellations
   task automatic random_sum(input int unsigned n_first, input int unsigned n_second);
      logic signed [spa_pkg::EXP_W-1:0]  used_exp [64];
      logic signed [spa_pkg::COEF_W-1:0] used_coef [64];
      int unsigned n_used;
      int unsigned left_first;
      int unsigned left_second;
      int unsigned idx;
      logic        op;
      logic        mark;
      logic        ended;
      logic signed [spa_pkg::COEF_W-1:0] coef;
      logic signed [spa_pkg::EXP_W-1:0]  expo;
      n_used = 0;
      left_first = n_first;
      left_second = n_second;
      ended = 1'b0;
      while (left_first + left_second > 0) begin
         if ($urandom_range(99) < 10)
            send_noise();
         op = ($urandom_range(left_first + left_second - 1) < left_first) ?
              spa_pkg::REQ_FIRST : spa_pkg::REQ_SECOND;
         coef = pick_coefficient();
         expo = pick_exponent();
         mark = 1'b0;
         if (op == spa_pkg::REQ_FIRST) begin
            left_first--;
            // the end mark is ignored on the first operand
            mark = 1'($urandom_range(1));
            if (n_used < 64) begin
               used_exp[n_used] = expo;
               used_coef[n_used] = coef;
               n_used++;
            end
         end else begin
            left_second--;
            if (n_used > 0 && $urandom_range(99) < 40) begin
               idx = $urandom_range(n_used - 1);
               expo = used_exp[idx];
               coef = $urandom_range(1) ? -used_coef[idx] : used_coef[idx];
            end
            // the final second-operand term may carry the end mark itself
            if (left_first + left_second == 0 && $urandom_range(1)) begin
               mark = 1'b1;
               ended = 1'b1;
            end
         end
         send_request(op, coef, expo, 1'b0, mark);
         random_items++;
      end
      if (!ended) begin
         send_request(spa_pkg::REQ_SECOND, pick_coefficient(), pick_exponent(), 1'b1, 1'b1);
         random_items++;
      end
   endtask

   task automatic test_random_sums();
      logic drained;
      drained = 1'b0;
      while (request_count < ITEM_TARGET) begin
         // a stretch in the middle runs back to back with no idle cycles
         idle_enable = !(request_count >= 50 && request_count < 90);
         if (!drained && request_count >= 100) begin
            wait_drained();
            drained = 1'b1;
         end
         // mostly small operands, now and then past the store capacity
         if (request_count + BIG_SUM_ROOM < ITEM_TARGET && $urandom_range(7) == 0)
            random_sum($urandom_range(TERM_CAP + 2, TERM_CAP - 2),
                       $urandom_range(TERM_CAP + 2, TERM_CAP - 2));
         else
            random_sum($urandom_range(5), $urandom_range(5));
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = spa_pkg::REQ_FIRST;
      req_coef_in   = '0;
      req_exp_in    = '0;
      req_no_term   = 1'b0;
      req_last_term = 1'b0;
      idle_enable   = 1'b1;
      op_count[spa_pkg::REQ_FIRST]  = 0;
      op_count[spa_pkg::REQ_SECOND] = 0;
      drop_seen     = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extreme_terms();
      test_cancelled_and_empty();
      test_first_end_mark_ignored();
      test_repeated_exponents();
      wait_drained();
      test_random_sums();

      // let the last sum finish, then allow for any stray strobes
      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("sent %0d requests (%0d in random sums), checked %0d sum terms", request_count,
               random_items, terms_checked);
      $display("%0d sums completed, %0d with dropped terms, %0d mismatches", sums_done,
               dropped_sums, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
